>>> rtl/terminal_line_discipline_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the terminal line discipline
// Concurrent checks clocked on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_DISCIPLINE_UNIT_ASSERT_SVH
`define TERMINAL_LINE_DISCIPLINE_UNIT_ASSERT_SVH

// Check that an expression holds at every clock edge
`define TLD_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tld check failed");

// Check that a condition leads to a consequence in the following cycle
`define TLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tld check failed");

`endif

>>> rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Types, codes and constants shared by the terminal line discipline files.
// ----------------------------------------------------------------------------
package tld_pkg;

	// configuration port and result field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RC_W       = 9;
	localparam int N_ECHO     = 6;
	localparam int ECNT_W     = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE  = 3'd0,
		CFG_OPTS  = 3'd1,
		CFG_FLOW  = 3'd2,
		CFG_ERASE = 3'd3,
		CFG_KILL  = 3'd4,
		CFG_EOF   = 3'd5,
		CFG_BELL  = 3'd6
	} cfg_reg_t;

	// input modes; every other code is cooked
	localparam logic [1:0] MODE_RAW    = 2'd0;
	localparam logic [1:0] MODE_CBREAK = 2'd1;

	// option flag bit positions
	localparam int OPT_CRLF  = 0;
	localparam int OPT_FLOW  = 1;
	localparam int OPT_ECHO  = 2;
	localparam int OPT_ERASE = 3;
	localparam int OPT_KILL  = 4;
	localparam int OPT_EOF   = 5;
	localparam int OPT_VIS   = 6;
	localparam int OPT_EBACK = 7;
	localparam int OPT_ECRLF = 8;

	// register values after reset
	localparam logic [1:0]  RST_MODE  = 2'd2;
	localparam logic [8:0]  RST_OPTS  = 9'h1FF;
	localparam logic [15:0] RST_FLOW  = 16'h1311;
	localparam logic [15:0] RST_ERASE = 16'h7F08;
	localparam logic [7:0]  RST_KILL  = 8'd21;
	localparam logic [7:0]  RST_EOF   = 8'd4;
	localparam logic [7:0]  RST_BELL  = 8'd7;

	// character constants
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_SP     = 8'd32;
	localparam logic [7:0] CH_UP     = 8'd94;
	localparam logic [7:0] CH_DEL    = 8'o177;
	localparam logic [7:0] CH_CTLOFS = 8'o100;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_NONE  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	// what the result builder does for one item
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_POP,
		ACT_EMPTY,
		ACT_ECHO,
		ACT_BELL,
		ACT_KILL,
		ACT_RUB
	} act_t;

	// item between the update stage and the result builder
	typedef struct packed {
		act_t            act;
		logic [7:0]      echo_c;
		logic            held;
		logic [RC_W-1:0] rc;
	} s2_t;

	// result list handed to the output stage
	typedef struct packed {
		kind_t                  kind;
		logic [ECNT_W-1:0]      cnt;
		logic [N_ECHO-1:0][7:0] bytes;
		logic                   held;
		logic [RC_W-1:0]        rc;
	} em_load_t;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c < CH_SP) || (c == CH_DEL);
	endfunction

endpackage

>>> rtl/tld_if.sv
// ----------------------------------------------------------------------------
// tld_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface tld_in_if;
	import tld_pkg::*;

	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] in_byte;

	modport source(output valid, func, in_byte, input ready);
	modport sink(input valid, func, in_byte, output ready);
endinterface

interface tld_out_if;
	import tld_pkg::*;

	logic            valid;
	logic            ready;
	kind_t           kind;
	logic [7:0]      out_byte;
	logic            last;
	logic            held;
	logic [RC_W-1:0] released_count;

	modport source(output valid, kind, out_byte, last, held, released_count, input ready);
	modport sink(input valid, kind, out_byte, last, held, released_count, output ready);
endinterface

>>> rtl/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write, and hold read data until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tld_emit.sv
// ----------------------------------------------------------------------------
// tld_emit
// Output stage: takes a list of up to six result bytes and sends one beat
// per cycle while the receiver is ready, marking the final beat of the list.
// ----------------------------------------------------------------------------
`include "terminal_line_discipline_unit_assert.svh"

module tld_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_valid,
	input  tld_pkg::em_load_t ld,
	output logic              free,
	tld_out_if.source         rsp
);
	import tld_pkg::*;

	logic                   em_valid_q;
	logic [ECNT_W-1:0]      em_left_q;
	logic [N_ECHO-1:0][7:0] em_bytes_q;
	kind_t                  em_kind_q;
	logic                   em_held_q;
	logic [RC_W-1:0]        em_rc_q;
	logic                   beat;
	logic                   final_beat;
	logic                   load;

	assign beat       = em_valid_q && rsp.ready;
	assign final_beat = (em_left_q == ECNT_W'(1));
	assign free       = !em_valid_q || (rsp.ready && final_beat);
	assign load       = ld_valid && free;

	// track how many beats of the list remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_left_q  <= '0;
		end else if (load) begin
			em_valid_q <= 1'b1;
			em_left_q  <= ld.cnt;
		end else if (beat) begin
			if (final_beat) begin
				em_valid_q <= 1'b0;
			end
			em_left_q <= em_left_q - ECNT_W'(1);
		end
	end

	// load the list, or advance it by one byte per beat
	always_ff @(posedge clk) begin
		if (load) begin
			em_bytes_q <= ld.bytes;
			em_kind_q  <= ld.kind;
			em_held_q  <= ld.held;
			em_rc_q    <= ld.rc;
		end else if (beat) begin
			em_bytes_q <= {8'h00, em_bytes_q[N_ECHO-1:1]};
		end
	end

	assign rsp.valid          = em_valid_q;
	assign rsp.kind           = em_kind_q;
	assign rsp.out_byte       = em_bytes_q[0];
	assign rsp.last           = final_beat;
	assign rsp.held           = em_held_q;
	assign rsp.released_count = em_rc_q;

	`TLD_ASSERT(a_left_nonzero, !em_valid_q || (em_left_q != '0))
	`TLD_ASSERT(a_list_len, !load || ((ld.cnt != '0) && (ld.cnt <= ECNT_W'(N_ECHO))))

endmodule

>>> rtl/terminal_line_discipline_unit.sv
// Items pass the builder register, then the output registers. Throughput: one
// result beat per cycle while the receiver is ready; an item with n results
// (1 to 6) holds the output stage until its last beat, so single-result items
// flow at one per cycle. The single line-store RAM port pair sets the update pace:
// at most one access per item. Reset: registers return to their defaults, indexes
// and counts clear, the line store keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// terminal_line_discipline_unit
// Terminal input line editor: ring buffer in RAM, raw, cbreak and cooked
// modes, echo generation and reader pops.
// ----------------------------------------------------------------------------
`include "terminal_line_discipline_unit_assert.svh"

module terminal_line_discipline_unit #(
	parameter int BUF_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tld_in_if.sink                         req,
	tld_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tld_pkg::*;

	localparam int IDX_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(BUF_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

	// configuration registers
	logic [1:0]  mode_q;
	logic [8:0]  opt_q;
	logic [15:0] flow_q;
	logic [15:0] erase_q;
	logic [7:0]  kill_q;
	logic [7:0]  eof_q;
	logic [7:0]  bell_q;

	// editor state
	logic [IDX_W-1:0] wi_q, wi_d;
	logic [IDX_W-1:0] ri_q, ri_d;
	logic [CNT_W-1:0] avail_q, avail_d;
	logic [IDX_W-1:0] cur_q, cur_d;
	logic             held_q, held_d;

	// update stage signals
	logic             acc;
	logic [7:0]       c;
	logic             echo_on;
	act_t             act_echo;
	act_t             act;
	logic [IDX_W-1:0] wi_inc, wi_dec, ri_inc, wi_kill;
	logic [SUM_W-1:0] fill;
	logic             full_nl, full_ch, avail_full;
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	// result builder stage
	logic     s2_valid_q;
	s2_t      s2_q;
	logic     s2_go;
	logic     em_free;
	em_load_t em_ld;
	logic     rub_vis;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			opt_q   <= RST_OPTS;
			flow_q  <= RST_FLOW;
			erase_q <= RST_ERASE;
			kill_q  <= RST_KILL;
			eof_q   <= RST_EOF;
			bell_q  <= RST_BELL;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODE:  mode_q  <= cfg_wdata[1:0];
				CFG_OPTS:  opt_q   <= cfg_wdata[8:0];
				CFG_FLOW:  flow_q  <= cfg_wdata;
				CFG_ERASE: erase_q <= cfg_wdata;
				CFG_KILL:  kill_q  <= cfg_wdata[7:0];
				CFG_EOF:   eof_q   <= cfg_wdata[7:0];
				CFG_BELL:  bell_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// accept while the builder stage is empty or moving on
	assign s2_go     = s2_valid_q && em_free;
	assign req.ready = !s2_valid_q || s2_go;
	assign acc       = req.valid && req.ready;

	// ring index arithmetic
	assign wi_inc  = (wi_q == LAST_IDX) ? '0 : wi_q + IDX_W'(1);
	assign wi_dec  = (wi_q == '0) ? LAST_IDX : wi_q - IDX_W'(1);
	assign ri_inc  = (ri_q == LAST_IDX) ? '0 : ri_q + IDX_W'(1);
	assign wi_kill = (wi_q >= cur_q) ? wi_q - cur_q : wi_q + (DEPTH_IDX - cur_q);

	// fill level checks
	assign fill       = SUM_W'(avail_q) + SUM_W'(cur_q);
	assign full_nl    = fill >= SUM_W'(BUF_DEPTH);
	assign full_ch    = fill >= SUM_W'(BUF_DEPTH - 1);
	assign avail_full = avail_q >= DEPTH_CNT;

	assign c        = (req.in_byte == CH_CR && opt_q[OPT_CRLF]) ? CH_NL : req.in_byte;
	assign echo_on  = opt_q[OPT_ECHO];
	assign act_echo = echo_on ? ACT_ECHO : ACT_NONE;

	// raw mode stores the byte exactly as it arrived
	assign ram_wdata = (mode_q == MODE_RAW) ? req.in_byte : c;

	// edit the state for the accepted item and issue the RAM access
	always_comb begin
		wi_d      = wi_q;
		ri_d      = ri_q;
		avail_d   = avail_q;
		cur_d     = cur_q;
		held_d    = held_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = ri_q;
		act       = ACT_NONE;
		if (acc) begin
			if (req.func) begin
				if (avail_q != '0) begin
					act     = ACT_POP;
					ram_re  = 1'b1;
					ri_d    = ri_inc;
					avail_d = avail_q - CNT_W'(1);
				end else begin
					act = ACT_EMPTY;
				end
			end else if (mode_q == MODE_RAW) begin
				if (!avail_full) begin
					ram_we  = 1'b1;
					wi_d    = wi_inc;
					avail_d = avail_q + CNT_W'(1);
				end
			end else if (opt_q[OPT_FLOW] && c == flow_q[7:0]) begin
				held_d = 1'b0;
			end else if (opt_q[OPT_FLOW] && c == flow_q[15:8]) begin
				held_d = 1'b1;
			end else begin
				held_d = 1'b0;
				if (mode_q == MODE_CBREAK) begin
					if (avail_full) begin
						act = ACT_BELL;
					end else begin
						ram_we  = 1'b1;
						wi_d    = wi_inc;
						avail_d = avail_q + CNT_W'(1);
						act     = act_echo;
					end
				end else if (c == kill_q && opt_q[OPT_KILL]) begin
					wi_d  = wi_kill;
					cur_d = '0;
					act   = ACT_KILL;
				end else if ((c == erase_q[7:0] || c == erase_q[15:8]) && opt_q[OPT_ERASE]) begin
					if (cur_q != '0) begin
						cur_d     = cur_q - IDX_W'(1);
						wi_d      = wi_dec;
						ram_re    = 1'b1;
						ram_raddr = wi_dec;
						act       = echo_on ? ACT_RUB : ACT_NONE;
					end
				end else if (c == CH_NL || c == CH_CR) begin
					if (!full_nl) begin
						act     = act_echo;
						ram_we  = 1'b1;
						wi_d    = wi_inc;
						avail_d = avail_q + CNT_W'(cur_q) + CNT_W'(1);
						cur_d   = '0;
					end
				end else if (full_ch) begin
					act = ACT_BELL;
				end else if (c == eof_q && opt_q[OPT_EOF]) begin
					act = act_echo;
					if (cur_q == '0) begin
						ram_we  = 1'b1;
						wi_d    = wi_inc;
						avail_d = avail_q + CNT_W'(1);
					end
				end else begin
					act    = act_echo;
					cur_d  = cur_q + IDX_W'(1);
					ram_we = 1'b1;
					wi_d   = wi_inc;
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q    <= '0;
			ri_q    <= '0;
			avail_q <= '0;
			cur_q   <= '0;
			held_q  <= 1'b0;
		end else begin
			wi_q    <= wi_d;
			ri_q    <= ri_d;
			avail_q <= avail_d;
			cur_q   <= cur_d;
			held_q  <= held_d;
		end
	end

	// line store
	tld_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wi_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// advance the item into the builder stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (acc) begin
			s2_valid_q <= 1'b1;
		end else if (s2_go) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s2_q.act    <= act;
			s2_q.echo_c <= c;
			s2_q.held   <= held_d;
			s2_q.rc     <= RC_W'(avail_d);
		end
	end

	assign rub_vis = is_ctl(ram_rdata) && opt_q[OPT_VIS];

	// build the result list from the action and the RAM read data
	always_comb begin
		em_ld.kind  = KIND_ECHO;
		em_ld.cnt   = ECNT_W'(1);
		em_ld.bytes = '0;
		em_ld.held  = s2_q.held;
		em_ld.rc    = s2_q.rc;
		unique case (s2_q.act)
			ACT_NONE: begin
				em_ld.kind = KIND_NONE;
			end
			ACT_POP: begin
				em_ld.kind     = KIND_READ;
				em_ld.bytes[0] = ram_rdata;
			end
			ACT_EMPTY: begin
				em_ld.kind = KIND_EMPTY;
			end
			ACT_BELL: begin
				em_ld.bytes[0] = bell_q;
			end
			ACT_KILL: begin
				em_ld.bytes[0] = CH_CR;
				em_ld.bytes[1] = CH_NL;
				em_ld.cnt      = ECNT_W'(2);
			end
			ACT_ECHO: begin
				if ((s2_q.echo_c == CH_NL || s2_q.echo_c == CH_CR) && opt_q[OPT_ECRLF]) begin
					em_ld.bytes[0] = CH_CR;
					em_ld.bytes[1] = CH_NL;
					em_ld.cnt      = ECNT_W'(2);
				end else if (is_ctl(s2_q.echo_c) && opt_q[OPT_VIS]) begin
					em_ld.bytes[0] = CH_UP;
					em_ld.bytes[1] = s2_q.echo_c + CH_CTLOFS;
					em_ld.cnt      = ECNT_W'(2);
				end else begin
					em_ld.bytes[0] = s2_q.echo_c;
				end
			end
			ACT_RUB: begin
				// a visual control byte takes two columns to rub out
				if (opt_q[OPT_EBACK]) begin
					em_ld.bytes = {CH_BS, CH_SP, CH_BS, CH_BS, CH_SP, CH_BS};
					em_ld.cnt   = rub_vis ? ECNT_W'(6) : ECNT_W'(3);
				end else begin
					em_ld.bytes[0] = CH_BS;
					em_ld.bytes[1] = CH_BS;
					em_ld.cnt      = rub_vis ? ECNT_W'(2) : ECNT_W'(1);
				end
			end
			default: begin
				em_ld.kind = KIND_NONE;
			end
		endcase
	end

	// output stage
	tld_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld_valid(s2_valid_q),
		.ld      (em_ld),
		.free    (em_free),
		.rsp     (rsp)
	);

	`TLD_ASSERT(a_ram_one_access, !(ram_we && ram_re))
	`TLD_ASSERT(a_avail_bound, avail_q <= DEPTH_CNT)
	`TLD_ASSERT_NEXT(a_s2_holds, s2_valid_q && !em_free, s2_valid_q)
	`TLD_ASSERT_NEXT(a_held_only_on_arrival, !acc || req.func, $stable(held_q))

endmodule

>>> test/tb_terminal_line_discipline_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_line_discipline_unit
// Self-checking bench for the terminal line discipline. A queue of keystrokes
// and reader pops feeds a valid/ready driver. Each accepted beat runs through
// a line editor model kept here, which queues the echo, read and status
// beats. The monitor compares every result beat field by field. Phases cover
// raw, cbreak and cooked modes, extreme register settings, a full buffer and
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_terminal_line_discipline_unit;
	import tld_pkg::*;

	localparam int DEPTH       = 256;
	localparam int LIMIT       = 3000000;
	localparam int DRAIN       = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int SHOW_MAX    = 10;

	localparam logic [1:0] MODE_COOKED     = 2'd2;
	localparam logic [1:0] MODE_COOKED_ALT = 2'd3;

	typedef struct packed {
		logic       func;
		logic [7:0] ch;
	} keystroke_t;

	typedef struct packed {
		kind_t           kind;
		logic [7:0]      data;
		logic            last;
		logic            held;
		logic [RC_W-1:0] count;
	} line_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tld_in_if  req_ch();
	tld_out_if rsp_ch();

	terminal_line_discipline_unit #(
		.BUF_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// register copies
	logic [1:0]  mode_r  = RST_MODE;
	logic [8:0]  opts_r  = RST_OPTS;
	logic [15:0] flow_r  = RST_FLOW;
	logic [15:0] erase_r = RST_ERASE;
	logic [7:0]  kill_r  = RST_KILL;
	logic [7:0]  eof_r   = RST_EOF;
	logic [7:0]  bell_r  = RST_BELL;

	// line editor state
	logic [7:0] ring [0:DEPTH-1];
	logic [7:0] wr_ptr = '0;
	logic [7:0] rd_ptr = '0;
	int         avail  = 0;
	int         cursor = 0;
	logic       held_r = 1'b0;
	logic [7:0] echo_run[$];

	keystroke_t typed_ahead[$];
	line_beat_t line_results_due[$];
	keystroke_t next_key;
	line_beat_t got_beat;
	line_beat_t want_beat;

	int   faults       = 0;
	logic in_taken     = 1'b0;
	int   send_gap     = 0;
	int   send_calm    = 0;
	int   recv_gap     = 0;
	int   recv_calm    = 0;
	logic hold_request = 1'b0;
	int   hold_left    = 0;
	logic hold_on      = 1'b0;
	int   cycle_no;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// line editor model
	// ------------------------------------------------------------------
	function automatic logic is_control(input logic [7:0] c);
		return (c < CH_SP) || (c == CH_DEL);
	endfunction

	function automatic void store_char(input logic [7:0] c);
		ring[wr_ptr] = c;
		wr_ptr++;
	endfunction

	function automatic void echo_char(input logic [7:0] c);
		if ((c == CH_NL || c == CH_CR) && opts_r[OPT_ECRLF]) begin
			echo_run.push_back(CH_CR);
			echo_run.push_back(CH_NL);
		end else if (is_control(c) && opts_r[OPT_VIS]) begin
			echo_run.push_back(CH_UP);
			echo_run.push_back(c + CH_CTLOFS);
		end else begin
			echo_run.push_back(c);
		end
	endfunction

	// step back over the last open byte and wipe it on screen
	function automatic void rub_out();
		logic [7:0] c;
		wr_ptr--;
		c = ring[wr_ptr];
		if (!opts_r[OPT_ECHO])
			return;
		if (is_control(c) && opts_r[OPT_VIS]) begin
			echo_run.push_back(CH_BS);
			if (opts_r[OPT_EBACK]) begin
				echo_run.push_back(CH_SP);
				echo_run.push_back(CH_BS);
			end
		end
		echo_run.push_back(CH_BS);
		if (opts_r[OPT_EBACK]) begin
			echo_run.push_back(CH_SP);
			echo_run.push_back(CH_BS);
		end
	endfunction

	function automatic void take_char(input logic [7:0] c_in);
		logic [7:0] c;
		logic       echo_on;
		c = c_in;
		echo_on = opts_r[OPT_ECHO];
		if (mode_r == MODE_RAW) begin
			if (avail >= DEPTH)
				return;
			store_char(c);
			avail++;
			return;
		end
		if (c == CH_CR && opts_r[OPT_CRLF])
			c = CH_NL;
		if (opts_r[OPT_FLOW]) begin
			if (c == flow_r[7:0]) begin
				held_r = 1'b0;
				return;
			end
			if (c == flow_r[15:8]) begin
				held_r = 1'b1;
				return;
			end
		end
		held_r = 1'b0;
		if (mode_r == MODE_CBREAK) begin
			if (avail >= DEPTH) begin
				echo_run.push_back(bell_r);
			end else begin
				store_char(c);
				avail++;
				if (echo_on)
					echo_char(c);
			end
			return;
		end
		// cooked: line editing
		if (c == kill_r && opts_r[OPT_KILL]) begin
			wr_ptr = wr_ptr - 8'(cursor);
			cursor = 0;
			echo_run.push_back(CH_CR);
			echo_run.push_back(CH_NL);
			return;
		end
		if ((c == erase_r[7:0] || c == erase_r[15:8]) && opts_r[OPT_ERASE]) begin
			if (cursor > 0) begin
				cursor--;
				rub_out();
			end
			return;
		end
		if (c == CH_NL || c == CH_CR) begin
			if (avail + cursor >= DEPTH)
				return;
			if (echo_on)
				echo_char(c);
			store_char(c);
			avail += cursor + 1;
			cursor = 0;
			return;
		end
		if (avail + cursor >= DEPTH - 1) begin
			echo_run.push_back(bell_r);
			return;
		end
		if (c == eof_r && opts_r[OPT_EOF]) begin
			if (echo_on)
				echo_char(c);
			if (cursor != 0)
				return;
			store_char(c);
			avail++;
			return;
		end
		if (echo_on)
			echo_char(c);
		cursor++;
		store_char(c);
	endfunction

	// queue the result beats of one accepted item
	function automatic void edit_line(input logic func, input logic [7:0] c);
		line_beat_t b;
		kind_t      kd;
		int         k;
		echo_run.delete();
		if (func) begin
			if (avail > 0) begin
				kd = KIND_READ;
				echo_run.push_back(ring[rd_ptr]);
				rd_ptr++;
				avail--;
			end else begin
				kd = KIND_EMPTY;
				echo_run.push_back(8'h00);
			end
		end else begin
			take_char(c);
			kd = KIND_ECHO;
			if (echo_run.size() == 0) begin
				kd = KIND_NONE;
				echo_run.push_back(8'h00);
			end
		end
		for (k = 0; k < echo_run.size(); k++) begin
			b.kind  = kd;
			b.data  = echo_run[k];
			b.last  = (k == echo_run.size() - 1);
			b.held  = held_r;
			b.count = RC_W'(avail);
			line_results_due.push_back(b);
		end
	endfunction

	// ------------------------------------------------------------------
	// idling
	// ------------------------------------------------------------------
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// input side: record accepted beats, then drive at the falling edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			edit_line(req_ch.func, req_ch.in_byte);
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (in_taken || !req_ch.valid)) begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (typed_ahead.size() > 0) begin
				next_key = typed_ahead.pop_front();
				req_ch.func    <= next_key.func;
				req_ch.in_byte <= next_key.ch;
				req_ch.valid   <= 1'b1;
				send_gap = pick_gap(send_calm);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// output side: long hold-off counter and random back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		hold_on = (hold_left > 0);
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_on) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				recv_gap = pick_gap(recv_calm);
			end
		end
	end

	function automatic void log_fault(input string what, input line_beat_t want,
			input line_beat_t got);
		faults++;
		if (faults <= SHOW_MAX)
			$display("%0s: expected kind %0d byte %02h last %0b held %0b count %0d, %s",
				what, want.kind, want.data, want.last, want.held, want.count,
				$sformatf("got kind %0d byte %02h last %0b held %0b count %0d",
				got.kind, got.data, got.last, got.held, got.count));
	endfunction

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_beat.kind  = rsp_ch.kind;
			got_beat.data  = rsp_ch.out_byte;
			got_beat.last  = rsp_ch.last;
			got_beat.held  = rsp_ch.held;
			got_beat.count = rsp_ch.released_count;
			if (line_results_due.size() == 0) begin
				log_fault("unexpected beat", '0, got_beat);
			end else begin
				want_beat = line_results_due.pop_front();
				if (got_beat.kind !== want_beat.kind || got_beat.data !== want_beat.data ||
						got_beat.last !== want_beat.last ||
						got_beat.held !== want_beat.held ||
						got_beat.count !== want_beat.count)
					log_fault("mismatch", want_beat, got_beat);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic type_char(input logic [7:0] c);
		typed_ahead.push_back('{func: 1'b0, ch: c});
	endtask

	task automatic type_pop();
		typed_ahead.push_back('{func: 1'b1, ch: 8'($urandom_range(0, 255))});
	endtask

	task automatic wait_idle();
		while (typed_ahead.size() != 0 || req_ch.valid || line_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_MODE:  mode_r  = v[1:0];
			CFG_OPTS:  opts_r  = v[8:0];
			CFG_FLOW:  flow_r  = v;
			CFG_ERASE: erase_r = v;
			CFG_KILL:  kill_r  = v[7:0];
			CFG_EOF:   eof_r   = v[7:0];
			CFG_BELL:  bell_r  = v[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [1:0] m, input logic [8:0] o,
			input logic [15:0] fl, input logic [15:0] er, input logic [7:0] kl,
			input logic [7:0] ef, input logic [7:0] bl);
		set_reg(CFG_MODE, 16'(m));
		set_reg(CFG_OPTS, 16'(o));
		set_reg(CFG_FLOW, fl);
		set_reg(CFG_ERASE, er);
		set_reg(CFG_KILL, 16'(kl));
		set_reg(CFG_EOF, 16'(ef));
		set_reg(CFG_BELL, 16'(bl));
	endtask

	// pop every released byte, then once more on the empty buffer
	task automatic drain_released();
		int n;
		n = avail;
		repeat (n + 1) type_pop();
	endtask

	function automatic logic [7:0] pick_special();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly printable text, some editing characters, some raw noise
	function automatic logic [7:0] line_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 8'($urandom_range(32, 126));
		if (r < 75) begin
			case ($urandom_range(0, 5))
				0: return erase_r[7:0];
				1: return erase_r[15:8];
				2: return kill_r;
				3: return eof_r;
				4: return flow_r[7:0];
				default: return flow_r[15:8];
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// lines of random content, most ended by NL or CR, then some reads
	task automatic type_lines(input int n);
		int made, len, j;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1))
					type_char(8'($urandom_range(0, 255)));
				else
					type_pop();
				made++;
			end else begin
				len = $urandom_range(0, 10);
				for (j = 0; j < len; j++)
					type_char(line_char());
				made += len;
				if ($urandom_range(0, 9) < 8) begin
					type_char($urandom_range(0, 1) ? CH_NL : CH_CR);
					made++;
				end
				for (j = $urandom_range(0, len + 2); j > 0; j--) begin
					type_pop();
					made++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------
	initial begin
		int         ph;
		int         j;
		int         n_fill;
		logic [1:0] m;
		logic [8:0] o;
		logic [7:0] fill;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.func    = 1'b0;
		req_ch.in_byte = '0;
		rsp_ch.ready   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, cooked with every option
		type_pop();
		type_char(8'h61);
		type_char(8'h00);
		type_char(8'hFF);
		type_char(CH_BS);
		type_char(CH_DEL);
		type_char(RST_FLOW[15:8]);
		type_char(8'h62);
		type_char(RST_FLOW[15:8]);
		type_char(RST_FLOW[7:0]);
		type_char(CH_CR);
		repeat (4) type_pop();
		type_char(RST_EOF);
		type_char(8'h78);
		type_char(RST_EOF);
		type_char(RST_KILL);
		type_char(CH_BS);
		type_char(CH_NL);
		type_char(8'h80);
		repeat (4) type_pop();
		wait_idle();

		// long receiver hold-off while the sender keeps offering
		@(posedge clk);
		send_calm = 200;
		@(negedge clk);
		hold_request = 1'b1;
		type_lines(40);
		wait_idle();

		// random phases over modes and register settings
		for (ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 1) begin
				drain_released();
				wait_idle();
			end
			m = (ph == 1) ? MODE_RAW :
				(ph == 2 || ph == 6) ? MODE_CBREAK :
				(ph == 3) ? MODE_COOKED_ALT : MODE_COOKED;
			o = (ph == 0) ? 9'h000 : (ph == 4) ? 9'h1FF : 9'($urandom_range(0, 511));
			if (ph == 5) begin
				fill = 8'h00;
				apply_settings(m, o, {fill, fill}, {fill, fill}, fill, fill, fill);
			end else if (ph == 7) begin
				fill = 8'hFF;
				apply_settings(m, o, {fill, fill}, {fill, fill}, fill, fill, fill);
			end else begin
				apply_settings(m, o, {pick_special(), pick_special()},
					{pick_special(), pick_special()}, pick_special(), pick_special(),
					8'($urandom_range(0, 255)));
			end
			type_lines(12);
			wait_idle();
		end

		// fill the buffer to the brim in cooked mode
		apply_settings(MODE_COOKED, RST_OPTS, RST_FLOW, RST_ERASE, RST_KILL, RST_EOF,
			RST_BELL);
		type_char(RST_KILL);
		n_fill = DEPTH - avail;
		for (j = 0; j < n_fill; j++)
			type_char(8'($urandom_range(65, 90)));
		type_char(CH_NL);
		type_char(8'($urandom_range(65, 90)));
		type_char(CH_CR);
		wait_idle();
		// full buffer in cbreak rings the bell, in raw drops the byte
		set_reg(CFG_MODE, 16'(MODE_CBREAK));
		type_char(8'($urandom_range(65, 90)));
		wait_idle();
		set_reg(CFG_MODE, 16'(MODE_RAW));
		type_char(8'($urandom_range(65, 90)));
		wait_idle();
		set_reg(CFG_MODE, 16'(MODE_COOKED));
		repeat (4) type_pop();
		wait_idle();

		if (line_results_due.size() != 0)
			faults++;
		if (faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// cycle limit
	initial begin
		for (cycle_no = 0; cycle_no < LIMIT; cycle_no++)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

endmodule
